>>> hw/rtl/oplf_pkg.sv
// shared types and constants for the ip option label finder
// no dependencies

package oplf_pkg;

    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] OPT_END  = 8'd0;
    localparam logic [7:0] OPT_NOOP = 8'd1;

    localparam logic [7:0] LABEL_TYPE_RST = 8'd158;
    localparam logic [5:0] LABEL_LEN_RST  = 6'd40;
    localparam logic [5:0] LABEL_LEN_MIN  = 6'd2;

    localparam logic [1:0] CFG_LABEL_TYPE = 2'd0;
    localparam logic [1:0] CFG_LABEL_LEN  = 2'd1;
    localparam logic [1:0] CFG_SCAN_MODE  = 2'd2;

    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    typedef enum logic [3:0] {
        PH_SEEK = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_SKIP = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0]       opt_byte;
        logic             first;
        logic             last;
        logic [POS_W-1:0] area_length;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] label_offset;
    } result_t;

endpackage

>>> hw/rtl/oplf_in_stage.sv
// input register that holds one option byte beat for the scan stage
// depends on oplf_pkg

module oplf_in_stage
    import oplf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_beat,
    input  logic     take,
    output logic     q_valid,
    output in_beat_t q_beat
);

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign q_valid = valid_reg;
    assign q_beat  = beat_reg;

endmodule

>>> hw/rtl/oplf_scan.sv
// option walk state, configuration registers and per-byte decision logic
// depends on oplf_pkg

module oplf_scan
    import oplf_pkg::*;
#(
    parameter int MAX_AREA_BYTES = 40
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       take,
    input  in_beat_t   beat,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [POS_W-1:0] MAX_L = POS_W'(MAX_AREA_BYTES);

    logic [7:0]       label_type_reg;
    logic [5:0]       label_len_reg;
    logic             scan_mode_reg;

    phase_t           phase_reg, phase_next, cur_phase;
    logic [POS_W-1:0] pos_reg, pos_next, cur_pos;
    logic [7:0]       skip_reg, skip_next, cur_skip;
    logic [POS_W-1:0] start_reg, start_next, cur_start;
    logic             cand_reg, cand_next, cur_cand;
    logic [POS_W-1:0] sal_reg, sal_next;
    logic [POS_W-1:0] limit;
    logic             end_here;
    logic [7:0]       skip_dec;
    logic [POS_W:0]   label_end;

    always_comb begin
        if (beat.first) begin
            sal_next  = beat.area_length;
            cur_phase = PH_SEEK;
            cur_pos   = '0;
            cur_skip  = '0;
            cur_start = '0;
            cur_cand  = 1'b0;
        end else begin
            sal_next  = sal_reg;
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_skip  = skip_reg;
            cur_start = start_reg;
            cur_cand  = cand_reg;
        end

        limit     = (sal_next > MAX_L) ? MAX_L : sal_next;
        end_here  = beat.last || (({1'b0, cur_pos} + 7'd1) == {1'b0, limit});
        skip_dec  = cur_skip - 8'd1;
        label_end = {1'b0, cur_start} + {1'b0, label_len_reg};

        phase_next = cur_phase;
        skip_next  = cur_skip;
        start_next = cur_start;
        cand_next  = cur_cand;
        res_valid  = 1'b0;
        res.status       = ST_ABSENT;
        res.label_offset = '0;

        if (cur_phase != PH_DONE) begin
            if (cur_pos >= limit) begin
                res_valid  = 1'b1;
                phase_next = PH_DONE;
            end else begin
                unique case (cur_phase)
                    PH_SEEK: begin
                        if (beat.opt_byte == label_type_reg) begin
                            if (end_here) begin
                                res_valid  = 1'b1;
                                phase_next = PH_DONE;
                            end else begin
                                start_next = cur_pos;
                                cand_next  = 1'b1;
                                phase_next = PH_LEN;
                            end
                        end else if (beat.opt_byte == OPT_END) begin
                            res_valid  = 1'b1;
                            phase_next = PH_DONE;
                        end else if (scan_mode_reg || beat.opt_byte == OPT_NOOP
                                     || end_here) begin
                            if (end_here) begin
                                res_valid  = 1'b1;
                                phase_next = PH_DONE;
                            end
                        end else begin
                            start_next = cur_pos;
                            cand_next  = 1'b0;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        res_valid = 1'b1;
                        if (cur_cand) begin
                            phase_next = PH_DONE;
                            if (beat.opt_byte != {2'b00, label_len_reg}
                                || label_len_reg < LABEL_LEN_MIN) begin
                                res.status = ST_BAD;
                            end else if (!scan_mode_reg && label_end > {1'b0, limit}) begin
                                res.status = ST_BAD;
                            end else begin
                                res.status       = ST_FOUND;
                                res.label_offset = cur_start;
                            end
                        end else if (beat.opt_byte < 8'd2) begin
                            res.status = ST_BAD;
                            phase_next = PH_DONE;
                        end else if (end_here) begin
                            phase_next = PH_DONE;
                        end else begin
                            res_valid  = 1'b0;
                            skip_next  = beat.opt_byte - 8'd2;
                            phase_next = (beat.opt_byte == 8'd2) ? PH_SEEK : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (end_here) begin
                            res_valid  = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0) begin
                                phase_next = PH_SEEK;
                            end
                        end
                    end
                    default: begin
                        phase_next = cur_phase;
                    end
                endcase
            end
        end

        pos_next = (cur_pos != POS_MAX) ? cur_pos + 6'd1 : cur_pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            label_type_reg <= LABEL_TYPE_RST;
            label_len_reg  <= LABEL_LEN_RST;
            scan_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LABEL_TYPE: label_type_reg <= cfg_data;
                CFG_LABEL_LEN:  label_len_reg  <= cfg_data[5:0];
                CFG_SCAN_MODE:  scan_mode_reg  <= cfg_data[0];
                default:        label_type_reg <= label_type_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK;
            pos_reg   <= '0;
            skip_reg  <= '0;
            start_reg <= '0;
            cand_reg  <= 1'b0;
            sal_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            start_reg <= start_next;
            cand_reg  <= cand_next;
            sal_reg   <= sal_next;
        end
    end

endmodule

>>> hw/rtl/oplf_out_stage.sv
// result register that holds one scan result until the sink takes it
// depends on oplf_pkg

module oplf_out_stage
    import oplf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

>>> hw/rtl/ip_option_label_finder.sv
// top level of the ip option label finder: input register, scan stage, result register
// depends on oplf_pkg, oplf_in_stage, oplf_scan, oplf_out_stage

// Takes an IPv4 options area one byte per beat (tuser marks the first byte, tlast the final
// one) and returns one beat per area: label found with its offset, absent, or malformed.
// One byte is accepted every cycle unless a result beat is stalled; each byte passes through
// an input register, a single combinational scan step and a result register, so the result
// beat is loaded into the result register as the deciding byte leaves the input register.
// The walk state of one area lives in the scan stage and is updated once per byte, which
// sets the rate at one byte per cycle; a result beat held by the sink stalls the input.
// The user must write configuration only while the block is idle; the block does not enforce
// this. There is no clearing pass after reset.

module ip_option_label_finder
    import oplf_pkg::*;
#(
    parameter int MAX_AREA_BYTES = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // opt_byte, area_length, zero fill
    input  logic        s_tlast,
    input  logic        s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status, label_offset
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    in_beat_t s_beat;
    in_beat_t q_beat;
    logic     q_valid;
    logic     out_valid;
    logic     take;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_beat.opt_byte    = s_tdata[7:0];
    assign s_beat.area_length = s_tdata[13:8];
    assign s_beat.first       = s_tuser;
    assign s_beat.last        = s_tlast;

    assign take = q_valid && (!out_valid || m_tready);

    oplf_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_beat  (s_beat),
        .take    (take),
        .q_valid (q_valid),
        .q_beat  (q_beat)
    );

    oplf_scan #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .beat      (q_beat),
        .res_valid (res_valid),
        .res       (res)
    );

    oplf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && res_valid),
        .load_res (res),
        .m_valid  (out_valid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {m_res.label_offset, m_res.status};

endmodule

>>> hw/rtl/oplf_checker.sv
// port-level checks for the ip option label finder, bound to the top level
// depends on ip_option_label_finder ports only

module oplf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("unknown status code");

    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[7:2] == 6'd0)
        else $error("offset set without a found label");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

endmodule

bind ip_option_label_finder oplf_checker u_oplf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
